@@ rtl/vertex_transform_4x4_defines.svh @@
// Assertion macros for the vertex transform RTL.
`ifndef VERTEX_TRANSFORM_4X4_DEFINES_SVH
`define VERTEX_TRANSFORM_4X4_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define VT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define VT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/vt_pkg.sv @@
// Shared types and codes for the vertex transform.
`timescale 1ns / 1ps
package vt_pkg;

    typedef enum logic [1:0] {
        FUNC_GENERAL   = 2'd0,
        FUNC_POINT     = 2'd1,
        FUNC_DIRECTION = 2'd2,
        FUNC_RESERVED  = 2'd3
    } func_t;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [31:0] in_x;
        logic signed [31:0] in_y;
        logic signed [31:0] in_z;
        logic signed [31:0] in_w;
    } vt_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_w;
        logic               divided;
        logic               saturated;
    } vt_out_t;

    localparam int NUM_REGS = 8;
    localparam int REG_BITS = 64;
    localparam int IDX_BITS = 3;

endpackage

@@ rtl/vertex_transform_4x4.sv @@
// Top level: 4x4 matrix by vector transform with optional perspective divide.
// Pipeline registers: the dot-product products and rounded sums, the divider setup,
// one divider stage per quotient bit, and the output register.
// Throughput: one word per cycle; every stage is a pipeline register, so a new
// word enters each cycle unless the output word is held by m_ready low.
// Reset: aresetn is synchronous active low; it clears valid bits and loads identity.
`timescale 1ns / 1ps
`include "vertex_transform_4x4_defines.svh"
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  vt_pkg::vt_in_t                   s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output vt_pkg::vt_out_t                  m_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [vt_pkg::IDX_BITS-1:0]      cfg_index,
    input  logic [vt_pkg::REG_BITS-1:0]      cfg_data
);
    import vt_pkg::*;

    localparam int N = WORD_BITS + FRAC_BITS;
    localparam int S = N + 4;                    // total stage count
    localparam int EPS = (1 << FRAC_BITS) / 10000;
    localparam logic signed [WORD_BITS-1:0] EPS_POS = WORD_BITS'(EPS);
    localparam logic signed [WORD_BITS-1:0] EPS_NEG = -WORD_BITS'(EPS);
    localparam logic signed [31:0] EPS_OUT = 32'(EPS);

    // ---------------- matrix registers ----------------
    logic [REG_BITS-1:0] mat_reg [NUM_REGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[0] <= 64'd65536;
            mat_reg[1] <= '0;
            mat_reg[2] <= 64'd65536 << 32;
            mat_reg[3] <= '0;
            mat_reg[4] <= '0;
            mat_reg[5] <= 64'd65536;
            mat_reg[6] <= '0;
            mat_reg[7] <= 64'd65536 << 32;
        end else if (cfg_valid && cfg_ready) begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // Entry k sits in register k/2, low half for even k, high half for odd k.
    logic signed [WORD_BITS-1:0] ent [16];
    for (genvar k = 0; k < 16; k++) begin : g_ent
        assign ent[k] = mat_reg[k/2][(k%2)*32 +: WORD_BITS];
    end

    // ---------------- pipeline control ----------------
    // Single enable: the whole pipe moves unless the output word is stuck.
    logic         en;
    logic [S-1:0] vld_reg;

    assign en      = !vld_reg[S-1] || m_ready;
    assign s_ready = en;
    assign m_valid = vld_reg[S-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[S-2:0], s_valid};
        end
    end

    // ---------------- input vector, w forced by mode ----------------
    logic signed [WORD_BITS-1:0] vec [4];
    always_comb begin
        vec[0] = s_data.in_x[WORD_BITS-1:0];
        vec[1] = s_data.in_y[WORD_BITS-1:0];
        vec[2] = s_data.in_z[WORD_BITS-1:0];
        case (s_data.func)
            FUNC_POINT:     vec[3] = WORD_BITS'(1) << FRAC_BITS;
            FUNC_DIRECTION: vec[3] = '0;
            default:        vec[3] = s_data.in_w[WORD_BITS-1:0];
        endcase
    end

    // ---------------- dot-product lanes, one per row ----------------
    logic signed [WORD_BITS-1:0] row_r   [4];
    logic                        row_sat [4];

    for (genvar r = 0; r < 4; r++) begin : g_row
        logic signed [WORD_BITS-1:0] row_e [4];
        for (genvar j = 0; j < 4; j++) begin : g_e
            assign row_e[j] = ent[4*r+j];
        end
        vt_dot_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_dot (
            .aclk  (aclk),
            .en    (en),
            .row_e (row_e),
            .vec   (vec),
            .res   (row_r[r]),
            .sat   (row_sat[r])
        );
    end

    logic [1:0] func_d1_reg, func_d2_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            func_d1_reg <= s_data.func;
            func_d2_reg <= func_d1_reg;
        end
    end

    // Divide only for points with |w| clear of zero.
    logic use_div, dot_sat;
    assign use_div = (func_d2_reg == FUNC_POINT) &&
                     (row_r[3] > EPS_POS || row_r[3] < EPS_NEG);
    assign dot_sat = row_sat[0] | row_sat[1] | row_sat[2] | row_sat[3];

    // ---------------- divider lanes for x, y, z ----------------
    logic signed [WORD_BITS-1:0] div_r   [3];
    logic                        div_sat [3];

    for (genvar c = 0; c < 3; c++) begin : g_div
        vt_div_lane #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) u_div (
            .aclk    (aclk),
            .en      (en),
            .num     (row_r[c]),
            .den     (row_r[3]),
            .use_div (use_div),
            .res     (div_r[c]),
            .sat     (div_sat[c])
        );
    end

    // w, divide flag and early saturation ride alongside the divider.
    logic signed [WORD_BITS-1:0] w_reg   [N+1];
    logic                        udiv_reg [N+1];
    logic                        dsat_reg [N+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg[0]    <= row_r[3];
            udiv_reg[0] <= use_div;
            dsat_reg[0] <= dot_sat;
            for (int k = 1; k <= N; k++) begin
                w_reg[k]    <= w_reg[k-1];
                udiv_reg[k] <= udiv_reg[k-1];
                dsat_reg[k] <= dsat_reg[k-1];
            end
        end
    end

    // ---------------- merge and output register ----------------
    vt_out_t out_reg, out_next;

    always_comb begin
        out_next.out_x     = 32'(div_r[0]);
        out_next.out_y     = 32'(div_r[1]);
        out_next.out_z     = 32'(div_r[2]);
        out_next.out_w     = 32'(w_reg[N]);
        out_next.divided   = udiv_reg[N];
        out_next.saturated = dsat_reg[N] | div_sat[0] | div_sat[1] | div_sat[2];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

    // ---------------- checks ----------------
    logic w_clear;
    assign w_clear = (m_data.out_w > EPS_OUT) || (m_data.out_w < -EPS_OUT);

    `VT_ASSERT_NOW(a_ready_rule, 1'b1, s_ready == (!m_valid || m_ready), "ready mismatch")
    `VT_ASSERT_NEXT(a_hold_out, m_valid && !m_ready, m_valid && $stable(m_data), "output not held")
    `VT_ASSERT_NOW(a_div_w, m_valid && m_data.divided, w_clear, "divide with small w")

endmodule

@@ rtl/vt_dot_lane.sv @@
// One matrix row dot product: registered products, then rounded sum with clipping.
`timescale 1ns / 1ps
module vt_dot_lane #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [WORD_BITS-1:0] row_e [4],
    input  logic signed [WORD_BITS-1:0] vec   [4],
    output logic signed [WORD_BITS-1:0] res,
    output logic                        sat
);
    localparam int PW = 2 * WORD_BITS;
    localparam int SW = 2 * WORD_BITS + 3;
    localparam logic signed [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic signed [SW-1:0] HI = {{(WORD_BITS+4){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] LO = {{(WORD_BITS+4){1'b1}}, {(WORD_BITS-1){1'b0}}};

    logic signed [PW-1:0]        prod_reg [4];
    logic signed [SW-1:0]        sum;
    logic signed [SW-1:0]        rnd;
    logic signed [WORD_BITS-1:0] res_reg, res_next;
    logic                        sat_reg, sat_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 4; j++) begin
                prod_reg[j] <= PW'(row_e[j]) * PW'(vec[j]);
            end
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    always_comb begin
        sum = HALF;
        for (int j = 0; j < 4; j++) begin
            sum = sum + SW'(prod_reg[j]);
        end
        rnd = sum >>> FRAC_BITS;
        if (rnd > HI) begin
            res_next = HI[WORD_BITS-1:0];
            sat_next = 1'b1;
        end else if (rnd < LO) begin
            res_next = LO[WORD_BITS-1:0];
            sat_next = 1'b1;
        end else begin
            res_next = rnd[WORD_BITS-1:0];
            sat_next = 1'b0;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

@@ rtl/vt_div_lane.sv @@
// Pipelined restoring divider for one component, one quotient bit per stage.
`timescale 1ns / 1ps
module vt_div_lane #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                        aclk,
    input  logic                        en,
    input  logic signed [WORD_BITS-1:0] num,
    input  logic signed [WORD_BITS-1:0] den,
    input  logic                        use_div,
    output logic signed [WORD_BITS-1:0] res,
    output logic                        sat
);
    localparam int N = WORD_BITS + FRAC_BITS;
    localparam logic [N-1:0] POS_MAX = {{(N-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic [N-1:0] NEG_MAG = N'(1) << (WORD_BITS - 1);

    logic [N-1:0]                dq_reg  [N+1];
    logic [WORD_BITS-1:0]        rem_reg [N+1];
    logic [WORD_BITS-1:0]        d_reg   [N+1];
    logic signed [WORD_BITS-1:0] num_reg [N+1];
    logic                        neg_reg [N+1];
    logic                        use_reg [N+1];

    logic [WORD_BITS-1:0] num_mag, den_mag;
    assign num_mag = num[WORD_BITS-1] ? WORD_BITS'(-num) : WORD_BITS'(num);
    assign den_mag = den[WORD_BITS-1] ? WORD_BITS'(-den) : WORD_BITS'(den);

    always_ff @(posedge aclk) begin
        if (en) begin
            dq_reg[0]  <= {num_mag, {FRAC_BITS{1'b0}}};
            rem_reg[0] <= '0;
            d_reg[0]   <= den_mag;
            num_reg[0] <= num;
            neg_reg[0] <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
            use_reg[0] <= use_div;
        end
    end

    for (genvar k = 1; k <= N; k++) begin : g_step
        logic [WORD_BITS:0] shifted, diff;
        logic               ge;
        assign shifted = {rem_reg[k-1], dq_reg[k-1][N-1]};
        assign diff    = shifted - {1'b0, d_reg[k-1]};
        assign ge      = shifted >= {1'b0, d_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
                dq_reg[k]  <= {dq_reg[k-1][N-2:0], ge};
                d_reg[k]   <= d_reg[k-1];
                num_reg[k] <= num_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                use_reg[k] <= use_reg[k-1];
            end
        end
    end

    always_comb begin
        res = num_reg[N];
        sat = 1'b0;
        if (use_reg[N]) begin
            if (neg_reg[N]) begin
                if (dq_reg[N] > NEG_MAG) begin
                    res = NEG_MAG[WORD_BITS-1:0];
                    sat = 1'b1;
                end else begin
                    res = -dq_reg[N][WORD_BITS-1:0];
                end
            end else begin
                if (dq_reg[N] > POS_MAX) begin
                    res = POS_MAX[WORD_BITS-1:0];
                    sat = 1'b1;
                end else begin
                    res = dq_reg[N][WORD_BITS-1:0];
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the 4x4 vertex transform with perspective divide.
`timescale 1ns / 1ps
module tb;
    import vt_pkg::*;

    localparam int LATENCY = 52;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [31:0] ONE = 32'h0001_0000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    typedef enum logic [2:0] {
        ROW0_LEFT, ROW0_RIGHT, ROW1_LEFT, ROW1_RIGHT,
        ROW2_LEFT, ROW2_RIGHT, ROW3_LEFT, ROW3_RIGHT
    } reg_idx_t;

    // Golden transform plus the queue of vertices still owed by the block.
    class xform_checker;
        logic [63:0] matrix [NUM_REGS];
        vt_out_t owed [$];
        int errors, n_in, n_out, n_div, n_sat;

        function new();
            matrix[ROW0_LEFT] = 64'd65536;
            matrix[ROW0_RIGHT] = 64'd0;
            matrix[ROW1_LEFT] = 64'd65536 << 32;
            matrix[ROW1_RIGHT] = 64'd0;
            matrix[ROW2_LEFT] = 64'd0;
            matrix[ROW2_RIGHT] = 64'd65536;
            matrix[ROW3_LEFT] = 64'd0;
            matrix[ROW3_RIGHT] = 64'd65536 << 32;
        endfunction

        function longint coef(int k);
            logic [63:0] rg;
            logic [31:0] half;
            rg = matrix[k >> 1];
            half = k[0] ? rg[63:32] : rg[31:0];
            return longint'($signed(half));
        endfunction

        function longint clip32(longint x, inout bit sat);
            if (x > 64'sd2147483647) begin
                sat = 1;
                return 64'sd2147483647;
            end
            if (x < -64'sd2147483648) begin
                sat = 1;
                return -64'sd2147483648;
            end
            return x;
        endfunction

        function vt_out_t transform_vertex(vt_in_t w);
            longint v [4];
            longint r [4];
            longint p, hi, lo;
            bit sat, dv;
            vt_out_t o;
            sat = 0;
            dv = 0;
            v[0] = longint'(w.in_x);
            v[1] = longint'(w.in_y);
            v[2] = longint'(w.in_z);
            v[3] = longint'(w.in_w);
            if (func_t'(w.func) == FUNC_POINT) v[3] = 65536;
            else if (func_t'(w.func) == FUNC_DIRECTION) v[3] = 0;
            for (int i = 0; i < 4; i++) begin
                hi = 0;
                lo = 32768;   // half an lsb: round to nearest, ties up
                for (int j = 0; j < 4; j++) begin
                    p = coef(4 * i + j) * v[j];
                    hi += p >>> 16;
                    lo += p & 64'hffff;
                end
                r[i] = clip32(hi + (lo >>> 16), sat);
            end
            // divide only when |w| clears 2^16/10000 raw
            if (func_t'(w.func) == FUNC_POINT && (r[3] > 6 || r[3] < -6)) begin
                dv = 1;
                for (int i = 0; i < 3; i++) r[i] = clip32((r[i] * 65536) / r[3], sat);
            end
            o.out_x = r[0][31:0];
            o.out_y = r[1][31:0];
            o.out_z = r[2][31:0];
            o.out_w = r[3][31:0];
            o.divided = dv;
            o.saturated = sat;
            return o;
        endfunction

        function void note_input(vt_in_t w);
            vt_out_t o;
            o = transform_vertex(w);
            owed.push_back(o);
            n_in++;
            n_div += o.divided;
            n_sat += o.saturated;
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch #%0d at word %0d: %s got %h want %h",
                     errors, n_out, what, got, want);
            errors++;
        endtask

        task check_result(vt_out_t got);
            vt_out_t want;
            if (owed.size() == 0) begin
                report("unexpected word", 0, 0);
                return;
            end
            want = owed.pop_front();
            if (got.out_x !== want.out_x) report("out_x", got.out_x, want.out_x);
            if (got.out_y !== want.out_y) report("out_y", got.out_y, want.out_y);
            if (got.out_z !== want.out_z) report("out_z", got.out_z, want.out_z);
            if (got.out_w !== want.out_w) report("out_w", got.out_w, want.out_w);
            if (got.divided !== want.divided) report("divided", got.divided, want.divided);
            if (got.saturated !== want.saturated)
                report("saturated", got.saturated, want.saturated);
            n_out++;
        endtask
    endclass

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    vt_in_t s_data = '0;
    logic m_valid;
    logic m_ready = 0;
    vt_out_t m_data;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0] cfg_data = '0;

    xform_checker sb = new();
    int cycles = 0;
    int cfg_writes = 0;
    bit hold_req = 0;     // sender asks the receiver for a long hold-off
    bit held = 0;         // long hold-off already done
    bit steady = 0;       // no idling on either side
    logic [63:0] next_mat [NUM_REGS];

    vertex_transform_4x4 uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result word accepted on the edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready = 0;
            end else if (hold_req && !held) begin
                m_ready = 0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                held = 1;
            end else if (steady) begin
                m_ready = 1;
            end else if (stall > 0) begin
                m_ready = 0;
                stall--;
            end else if ($urandom_range(0, 9) < 7) begin
                m_ready = 1;
            end else begin
                m_ready = 0;
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(0, 2);
            end
        end
    end

    function int pick_gap();
        if (steady) return 0;
        case ($urandom_range(0, 19))
            0: return $urandom_range(10, 40);
            1, 2, 3, 4, 5: return $urandom_range(1, 3);
            default: return 0;
        endcase
    endfunction

    // called at a falling edge; returns at a falling edge
    task send_vertex(logic [1:0] f, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                     logic [31:0] w);
        int gap;
        s_valid = 1;
        s_data = '{func: f, in_x: x, in_y: y, in_z: z, in_w: w};
        do @(posedge aclk); while (!s_ready);
        sb.note_input(s_data);
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task write_reg(reg_idx_t idx, logic [63:0] value);
        cfg_valid = 1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge aclk); while (!cfg_ready);
        sb.matrix[idx] = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // wait until every owed vertex is back and the pipe is empty
    task drain();
        s_valid = 0;
        while (sb.owed.size() > 0) @(negedge aclk);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    task load_matrix();
        drain();
        for (int i = 0; i < NUM_REGS; i++) write_reg(reg_idx_t'(i), next_mat[i]);
    endtask

    function logic [31:0] rand_coef(int style);
        case (style)
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;   // +-2.0
            2: return $urandom;
            default: case ($urandom_range(0, 4))
                0: return MAXV;
                1: return MINV;
                2: return 0;
                3: return ONE;
                default: return -ONE;
            endcase
        endcase
    endfunction

    function logic [31:0] rand_comp();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            5, 6, 7: return $urandom;
            8: return $urandom_range(0, 15) - 8;   // tiny, near the divide threshold
            default: return $urandom_range(0, 1) ? MAXV : MINV;
        endcase
    endfunction

    task random_vertex();
        logic [1:0] f;
        f = ($urandom_range(0, 9) < 4) ? FUNC_POINT : 2'($urandom_range(0, 3));
        send_vertex(f, rand_comp(), rand_comp(), rand_comp(), rand_comp());
    endtask

    task set_identity();
        next_mat[ROW0_LEFT] = {32'd0, ONE};
        next_mat[ROW0_RIGHT] = 64'd0;
        next_mat[ROW1_LEFT] = {ONE, 32'd0};
        next_mat[ROW1_RIGHT] = 64'd0;
        next_mat[ROW2_LEFT] = 64'd0;
        next_mat[ROW2_RIGHT] = {32'd0, ONE};
        next_mat[ROW3_LEFT] = 64'd0;
        next_mat[ROW3_RIGHT] = {ONE, 32'd0};
    endtask

    initial begin
        int style;
        repeat (12) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);

        // directed: identity from reset, every mode and the field extremes
        steady = 1;
        send_vertex(FUNC_GENERAL, 0, 0, 0, 0);
        send_vertex(FUNC_GENERAL, MAXV, MAXV, MAXV, MAXV);
        send_vertex(FUNC_GENERAL, MINV, MINV, MINV, MINV);
        send_vertex(FUNC_POINT, ONE, 2 * ONE, 3 * ONE, 0);
        send_vertex(FUNC_POINT, MAXV, MINV, -ONE, MAXV);
        send_vertex(FUNC_DIRECTION, MAXV, MINV, ONE, MAXV);
        send_vertex(FUNC_RESERVED, 32'h1234_5678, MINV, MAXV, 32'hdead_beef);
        send_vertex(FUNC_GENERAL, ONE, ONE, ONE, 0);   // w of zero, no divide in general

        // w taken from z: walk the divide threshold from both sides
        set_identity();
        next_mat[ROW3_RIGHT] = {32'd0, ONE};
        load_matrix();
        send_vertex(FUNC_POINT, 5 * ONE, -3 * ONE, 6, 0);
        send_vertex(FUNC_POINT, 5 * ONE, -3 * ONE, 7, 0);
        send_vertex(FUNC_POINT, 5 * ONE, -3 * ONE, -6, 0);
        send_vertex(FUNC_POINT, 5 * ONE, -3 * ONE, -7, 0);
        send_vertex(FUNC_POINT, ONE, ONE, 0, 0);
        send_vertex(FUNC_POINT, MAXV, MINV, 7, 0);     // quotient overflows both ways
        send_vertex(FUNC_POINT, MAXV, MINV, MINV, 0);
        send_vertex(FUNC_GENERAL, ONE, ONE, 7, ONE);

        // extreme matrices: every entry at full scale, so large sums clip
        for (int i = 0; i < NUM_REGS; i++) next_mat[i] = {MAXV, MAXV};
        load_matrix();
        send_vertex(FUNC_GENERAL, MAXV, MAXV, MAXV, MAXV);
        send_vertex(FUNC_GENERAL, MINV, MAXV, MINV, MAXV);
        send_vertex(FUNC_POINT, MINV, MINV, MINV, 0);
        for (int i = 0; i < NUM_REGS; i++) next_mat[i] = {MINV, MINV};
        load_matrix();
        send_vertex(FUNC_GENERAL, MINV, MINV, MINV, MINV);
        send_vertex(FUNC_DIRECTION, MAXV, MINV, MAXV, 0);
        steady = 0;

        // random phases, each under a fresh matrix
        for (int ph = 0; ph < 6; ph++) begin
            style = ph % 3;
            if (ph == 0) begin
                set_identity();
            end else begin
                for (int i = 0; i < NUM_REGS; i++)
                    next_mat[i] = {rand_coef(style), rand_coef(style)};
                // mostly projective: w driven by z so the divide fires often
                if (style == 1) next_mat[ROW3_RIGHT] = {32'd0, ONE};
            end
            load_matrix();
            if (ph == 2) begin
                // long receiver hold-off while words keep coming
                steady = 1;
                hold_req = 1;
                for (int n = 0; n < 120; n++) random_vertex();
                steady = 0;
                drain();
            end
            steady = (ph == 4);
            for (int n = 0; n < 140; n++) random_vertex();
            steady = 0;
        end

        drain();
        $display("run: %0d vertices in, %0d out, %0d divided, %0d saturated",
                 sb.n_in, sb.n_out, sb.n_div, sb.n_sat);
        $display("     %0d register writes over 9 matrices, %0d mismatches",
                 cfg_writes, sb.errors);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            if (sb.owed.size() > 0)
                $display("%0d vertices never came back", sb.owed.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
